/* sv/wrsd_pkg.sv */
// ----------------------------------------------------------------------------
// wrsd_pkg
// Shared types and constants for the wavelet row split-difference unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wrsd_pkg;

    // row geometry
    localparam int MAX_ROW_WIDTH = 128;
    localparam int BUF_DEPTH     = MAX_ROW_WIDTH / 2;
    localparam int SLOT_W        = $clog2(BUF_DEPTH);
    localparam int POS_W         = $clog2(MAX_ROW_WIDTH);

    // field widths
    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 8;

    // configuration defaults and limits
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(128);
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_MIN   = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_MAX   = WIDTH_W'(MAX_ROW_WIDTH);

    // detail bias subtracted from odd minus even
    localparam logic [PIX_W-1:0] DETAIL_BIAS = PIX_W'(128);

    // detail buffer: two halves of one row each, ping-pong by row
    localparam int RAM_DEPTH = 2 * BUF_DEPTH;
    localparam int RAM_AW    = SLOT_W + 1;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // one queued command: an approximation sample or a detail burst
    // for a burst, data holds the index of its last detail
    typedef struct packed {
        logic             is_burst;
        logic             bank;
        logic [PIX_W-1:0] data;
    } cmd_t;

    // burst completion from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } back_state_t;

endpackage

`default_nettype wire

/* sv/wrsd_ram.sv */
// ----------------------------------------------------------------------------
// wrsd_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/wrsd_fifo.sv */
// ----------------------------------------------------------------------------
// wrsd_fifo
// Short command queue that decouples the pixel front from the result back.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire wrsd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output wrsd_pkg::cmd_t     head
);

    wrsd_pkg::cmd_t                     mem_reg [wrsd_pkg::FIFO_DEPTH];
    logic [wrsd_pkg::FIFO_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [wrsd_pkg::FIFO_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [wrsd_pkg::FIFO_CW-1:0]       count_reg, count_next;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = (count_reg == wrsd_pkg::FIFO_CW'(wrsd_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* sv/wrsd_front.sv */
// ----------------------------------------------------------------------------
// wrsd_front
// Pixel front end: tracks the column, queues approximation samples, writes
// detail values into the row buffer and queues a burst at the end of a row.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsd_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wen,
    input  wire logic [wrsd_pkg::WIDTH_W-1:0]      cfg_wdata,
    // pixel word in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [wrsd_pkg::PIX_W-1:0]        s_tdata,
    // command queue
    input  wire logic                              fifo_full,
    output logic                                   push,
    output wrsd_pkg::cmd_t                         push_cmd,
    // burst completion from the back end
    input  wire wrsd_pkg::done_t                   done,
    // row buffer write port
    output logic                                   ram_we,
    output logic [wrsd_pkg::RAM_AW-1:0]            ram_waddr,
    output logic [wrsd_pkg::PIX_W-1:0]             ram_wdata
);

    logic [wrsd_pkg::WIDTH_W-1:0] row_width_reg;
    logic [wrsd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [wrsd_pkg::PIX_W-1:0]   held_reg, held_next;
    logic                         bank_reg, bank_next;
    logic [1:0]                   busy_reg, busy_next;

    logic [wrsd_pkg::WIDTH_W-1:0] w_eff;
    logic [wrsd_pkg::WIDTH_W-1:0] lim2;
    logic [wrsd_pkg::WIDTH_W-1:0] pos_ext;
    logic [wrsd_pkg::WIDTH_W-1:0] pos_inc;
    logic [wrsd_pkg::SLOT_W-1:0]  last_idx;
    logic                         in_range;
    logic                         is_odd;
    logic                         is_last;
    logic                         accept;

    // register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= wrsd_pkg::ROW_WIDTH_RESET;
        end else if (cfg_wen) begin
            row_width_reg <= cfg_wdata;
        end
    end

    // effective width and column classification
    always_comb begin
        priority if (row_width_reg < wrsd_pkg::ROW_WIDTH_MIN) begin
            w_eff = wrsd_pkg::ROW_WIDTH_MIN;
        end else if (row_width_reg > wrsd_pkg::ROW_WIDTH_MAX) begin
            w_eff = wrsd_pkg::ROW_WIDTH_MAX;
        end else begin
            w_eff = row_width_reg;
        end
    end

    assign lim2     = {w_eff[wrsd_pkg::WIDTH_W-1:1], 1'b0};
    assign last_idx = wrsd_pkg::SLOT_W'(w_eff[wrsd_pkg::WIDTH_W-1:1] - 1'b1);
    assign pos_ext  = wrsd_pkg::WIDTH_W'(pos_reg);
    assign pos_inc  = pos_ext + 1'b1;
    assign in_range = (pos_ext < lim2);
    assign is_odd   = pos_reg[0];
    assign is_last  = (pos_inc == lim2);

    // hold off an odd pixel while its buffer half is still being replayed
    assign s_tready = !fifo_full && !(in_range && is_odd && busy_reg[bank_reg]);
    assign accept   = s_tvalid && s_tready;

    // per-word work
    always_comb begin
        pos_next  = pos_reg;
        held_next = held_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        push      = 1'b0;
        push_cmd  = '{is_burst: 1'b0, bank: bank_reg, data: s_tdata};
        ram_we    = 1'b0;
        ram_waddr = {bank_reg, pos_reg[wrsd_pkg::POS_W-1:1]};
        ram_wdata = s_tdata - held_reg - wrsd_pkg::DETAIL_BIAS;

        if (done.valid) begin
            busy_next[done.bank] = 1'b0;
        end

        if (accept) begin
            if (in_range && !is_odd) begin
                held_next = s_tdata;
                push      = 1'b1;
            end
            if (in_range && is_odd) begin
                ram_we = 1'b1;
                if (is_last) begin
                    push               = 1'b1;
                    push_cmd.is_burst  = 1'b1;
                    push_cmd.data      = wrsd_pkg::PIX_W'(last_idx);
                    busy_next[bank_reg] = 1'b1;
                    bank_next          = !bank_reg;
                end
            end
            if (pos_inc >= w_eff) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc[wrsd_pkg::POS_W-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

    // held even pixel
    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

/* sv/wrsd_back.sv */
// ----------------------------------------------------------------------------
// wrsd_back
// Result back end: drains the command queue, passes approximation samples
// and replays a row's detail values from the buffer into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrsd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command queue
    input  wire logic                          head_valid,
    input  wire wrsd_pkg::cmd_t                head,
    output logic                               pop,
    // row buffer read port
    output logic                               ram_re,
    output logic [wrsd_pkg::RAM_AW-1:0]        ram_raddr,
    input  wire logic [wrsd_pkg::PIX_W-1:0]    ram_rdata,
    // burst completion to the front end
    output wrsd_pkg::done_t                    done,
    // result word out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [wrsd_pkg::PIX_W-1:0]         m_tdata,
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);

    wrsd_pkg::back_state_t        state_reg, state_next;
    logic [wrsd_pkg::SLOT_W-1:0]  k_reg, k_next;
    logic [wrsd_pkg::SLOT_W-1:0]  k_inc;
    logic [wrsd_pkg::SLOT_W-1:0]  last_reg, last_next;
    logic                         bank_reg, bank_next;

    logic                         valid_reg, valid_next;
    logic [wrsd_pkg::PIX_W-1:0]   coeff_reg, coeff_next;
    logic                         detail_reg, detail_next;
    logic                         end_reg, end_next;
    logic                         out_free;

    assign out_free = !valid_reg || m_tready;
    assign k_inc    = k_reg + 1'b1;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        last_next   = last_reg;
        bank_next   = bank_reg;
        valid_next  = valid_reg && !m_tready;
        coeff_next  = coeff_reg;
        detail_next = detail_reg;
        end_next    = end_reg;
        pop         = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = {bank_reg, k_reg};
        done        = '0;

        unique case (state_reg)
            wrsd_pkg::ST_IDLE: begin
                if (head_valid) begin
                    if (head.is_burst) begin
                        // start the burst with a read of its first entry
                        pop        = 1'b1;
                        bank_next  = head.bank;
                        last_next  = head.data[wrsd_pkg::SLOT_W-1:0];
                        k_next     = '0;
                        ram_re     = 1'b1;
                        ram_raddr  = {head.bank, {wrsd_pkg::SLOT_W{1'b0}}};
                        state_next = wrsd_pkg::ST_BURST;
                    end else if (out_free) begin
                        pop         = 1'b1;
                        valid_next  = 1'b1;
                        coeff_next  = head.data;
                        detail_next = 1'b0;
                        end_next    = 1'b0;
                    end
                end
            end
            wrsd_pkg::ST_BURST: begin
                // one detail per cycle while the output is free, next read issued with each word
                if (out_free) begin
                    valid_next  = 1'b1;
                    coeff_next  = ram_rdata;
                    detail_next = 1'b1;
                    end_next    = (k_reg == last_reg);
                    if (k_reg == last_reg) begin
                        done.valid = 1'b1;
                        done.bank  = bank_reg;
                        state_next = wrsd_pkg::ST_IDLE;
                    end else begin
                        k_next    = k_inc;
                        ram_re    = 1'b1;
                        ram_raddr = {bank_reg, k_inc};
                    end
                end
            end
            default: begin
                state_next = wrsd_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wrsd_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // burst position and output payload
    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        last_reg   <= last_next;
        bank_reg   <= bank_next;
        coeff_reg  <= coeff_next;
        detail_reg <= detail_next;
        end_reg    <= end_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = coeff_reg;
    assign m_tuser  = detail_reg;
    assign m_tlast  = end_reg;

endmodule

`default_nettype wire

/* sv/wavelet_row_split_difference_unit.sv */
// ----------------------------------------------------------------------------
// wavelet_row_split_difference_unit
// One row level of a Haar-style split: approximation samples pass straight
// through, detail values are buffered per row and replayed at row end.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the s_ stream, one word per cycle while
// s_tready is high. Each even-column pixel goes out at once as an
// approximation sample (tuser 0); each odd-column pixel yields
// (odd - even - 128) mod 256, stored in a row buffer, and after the last
// odd pixel of a row the row's w/2 detail values go out in column order
// (tuser 1), the last one with tlast. An odd width drops the final pixel of
// each row. The row buffer is one RAM split into two halves used by
// alternate rows, so a new row streams in while the last row's details are
// replayed. The output port sets the rate: one result per cycle while
// m_tready is high, except as a burst starts. Any pixel waits while the
// four-entry command queue is full, and an odd pixel also waits while the
// buffer half it needs still replays a row from two rows back. The buffer
// needs no clearing after reset; row_width is written through cfg_wen and
// cfg_wdata while the unit is idle, reset value 128, clamped to 2..128.
// ----------------------------------------------------------------------------
`default_nettype none

module wavelet_row_split_difference_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // row_width register
    input  wire logic       cfg_wen,
    input  wire logic [7:0] cfg_wdata,
    // pixel stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] pixel
    // result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] coeff
    output logic [0:0]      m_tuser,   // [0] is_detail
    output logic            m_tlast    // row_end
);

    logic                               push;
    wrsd_pkg::cmd_t                     push_cmd;
    logic                               fifo_full;
    logic                               pop;
    logic                               head_valid;
    wrsd_pkg::cmd_t                     head;
    wrsd_pkg::done_t                    done;

    logic                               ram_we;
    logic [wrsd_pkg::RAM_AW-1:0]        ram_waddr;
    logic [wrsd_pkg::PIX_W-1:0]         ram_wdata;
    logic                               ram_re;
    logic [wrsd_pkg::RAM_AW-1:0]        ram_raddr;
    logic [wrsd_pkg::PIX_W-1:0]         ram_rdata;

    // pixel front end
    wrsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .done      (done),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // command queue
    wrsd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // detail row buffer, two row halves
    wrsd_ram #(
        .DATA_W (wrsd_pkg::PIX_W),
        .DEPTH  (wrsd_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result back end
    wrsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .done       (done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* verif/wavelet_row_split_difference_unit_tb.sv */
// ----------------------------------------------------------------------------
// wavelet_row_split_difference_unit_tb
// Self-checking bench for the row split-difference unit: pixel rows go in
// under several row widths, and every result word is checked against a
// row-level model of the split (approximation copies, biased differences
// buffered per row and replayed with the row end marked).
// ----------------------------------------------------------------------------
`default_nettype none

module wavelet_row_split_difference_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected result word
    typedef struct packed {
        logic [wrsd_pkg::PIX_W-1:0] coeff;
        logic                       is_detail;
        logic                       row_end;
    } coeff_word_t;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 310;
    localparam int MAX_PRINTS = 40;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wen = 1'b0;
    logic [7:0]       cfg_wdata = 8'd0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'd0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic [0:0]       m_tuser;
    logic             m_tlast;

    // pixels waiting for the driver, results waiting for the monitor
    logic [wrsd_pkg::PIX_W-1:0] pixel_q[$];
    coeff_word_t      coeff_q[$];
    int               mismatch_count = 0;
    logic             steady = 1'b0;

    // row model state
    logic [wrsd_pkg::WIDTH_W-1:0] model_width = wrsd_pkg::ROW_WIDTH_RESET;
    logic [wrsd_pkg::POS_W-1:0]   model_col = '0;
    logic [wrsd_pkg::PIX_W-1:0]   model_even = '0;
    logic [wrsd_pkg::PIX_W-1:0]   model_details [wrsd_pkg::BUF_DEPTH];

    wavelet_row_split_difference_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // one line per mismatch up to MAX_PRINTS, every mismatch counted
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // split one accepted pixel and queue the results it causes
    function automatic void split_pixel(input logic [wrsd_pkg::PIX_W-1:0] px);
        int          w;
        int          half;
        int          col;
        coeff_word_t word;
        w = int'(model_width);
        if (w < int'(wrsd_pkg::ROW_WIDTH_MIN))
            w = int'(wrsd_pkg::ROW_WIDTH_MIN);
        if (w > int'(wrsd_pkg::ROW_WIDTH_MAX))
            w = int'(wrsd_pkg::ROW_WIDTH_MAX);
        half = w / 2;
        col = int'(model_col);
        if (col < 2 * half) begin
            if (col % 2 == 0) begin
                model_even = px;
                word.coeff = px;
                word.is_detail = 1'b0;
                word.row_end = 1'b0;
                coeff_q.push_back(word);
            end else begin
                model_details[(col / 2) % wrsd_pkg::BUF_DEPTH] =
                    px - model_even - wrsd_pkg::DETAIL_BIAS;
                // last odd pixel of the row: replay the whole detail row
                if (col == 2 * half - 1) begin
                    for (int k = 0; k < half; k++) begin
                        word.coeff = model_details[k % wrsd_pkg::BUF_DEPTH];
                        word.is_detail = 1'b1;
                        word.row_end = (k == half - 1);
                        coeff_q.push_back(word);
                    end
                end
            end
        end
        col++;
        if (col >= w)
            col = 0;
        model_col = wrsd_pkg::POS_W'(col);
    endfunction

    // pixel driver, predicts on every accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
        end else begin
            if (s_tvalid && s_tready)
                split_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pixel_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 15);
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        coeff_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (coeff_q.size() == 0) begin
                report_mismatch("unexpected word, coeff", int'(m_tdata), 0);
            end else begin
                want = coeff_q.pop_front();
                if (m_tdata !== want.coeff)
                    report_mismatch("coeff", int'(m_tdata), int'(want.coeff));
                if (m_tuser[0] !== want.is_detail)
                    report_mismatch("is_detail", int'(m_tuser[0]), int'(want.is_detail));
                if (m_tlast !== want.row_end)
                    report_mismatch("row_end", int'(m_tlast), int'(want.row_end));
            end
        end
    end

    // wait until every pixel is in and every result is out, then settle
    task automatic drain_results();
        do
            @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || coeff_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write row_width while idle and track it in the model
    task automatic load_row_width(input logic [7:0] value);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        model_width = value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic push_random_pixels(input int count);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(wrsd_pkg::PIX_W'($urandom_range(0, 255)));
    endtask

    // stimulus
    initial begin : stimulus
        int random_items;
        int width;
        int eff;
        int count;
        for (int i = 0; i < wrsd_pkg::BUF_DEPTH; i++)
            model_details[i] = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // above the maximum width: clamps to the full row, left mid-row
        load_row_width(8'd255);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        drain_results();

        // shrink mid-row past the column: one pixel dropped, new row after
        load_row_width(8'd2);
        pixel_q.push_back(8'h55);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'h80);
        pixel_q.push_back(8'h00);
        drain_results();

        // widths below the minimum act as two
        load_row_width(8'd0);
        pixel_q.push_back(8'h7F);
        pixel_q.push_back(8'h7F);
        drain_results();
        load_row_width(8'd1);
        pixel_q.push_back(8'h01);
        pixel_q.push_back(8'hFE);
        drain_results();

        // odd width: trailing pixel of each row gives nothing
        load_row_width(8'd3);
        pixel_q.push_back(8'h10);
        pixel_q.push_back(8'h90);
        pixel_q.push_back(8'hAA);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'h33);
        drain_results();

        // shrink mid-row ahead of the column: row ends at the new width
        load_row_width(8'd8);
        pixel_q.push_back(8'h20);
        pixel_q.push_back(8'hC0);
        pixel_q.push_back(8'h40);
        drain_results();
        load_row_width(8'd4);
        pixel_q.push_back(8'h00);
        drain_results();

        // one full-width row with no idling on either side
        load_row_width(8'd128);
        steady = 1'b1;
        push_random_pixels(wrsd_pkg::MAX_ROW_WIDTH);
        drain_results();
        steady = 1'b0;
        random_items = wrsd_pkg::MAX_ROW_WIDTH;

        // mostly whole rows of small widths, some cut short before a change
        while (random_items < RANDOM_ITEMS) begin
            width = $urandom_range(0, 20);
            eff = (width < 2) ? 2 : width;
            load_row_width(8'(width));
            count = $urandom_range(1, 4) * eff;
            if ($urandom_range(0, 5) == 0)
                count += $urandom_range(1, eff - 1);
            push_random_pixels(count);
            random_items += count;
            drain_results();
        end

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
